// ===== rtl/evmc_pkg.sv =====
`default_nettype none

package evmc_pkg;

	// Q7.8 volume, full scale is 100 percent
	localparam int unsigned VOLUME_FRAC_BITS = 8;
	localparam int unsigned VOLUME_W         = 15;
	localparam logic [VOLUME_W-1:0] VOLUME_MAX = VOLUME_W'(100 << VOLUME_FRAC_BITS);

	// configuration register widths
	localparam int unsigned STEP_W   = 15;
	localparam int unsigned TICKS_W  = 16;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned CFG_IDX_W = 3;

	// register indexes of the configuration port
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_OS_IS_MAC      = 3'd0,
		CFG_STEP_MAC       = 3'd1,
		CFG_STEP_WIN       = 3'd2,
		CFG_DEBOUNCE_TICKS = 3'd3,
		CFG_OVERLAY_TICKS  = 3'd4
	} cfg_index_t;

	// step event codes
	typedef enum logic [1:0] {
		STEP_NONE = 2'd0,
		STEP_UP   = 2'd1,
		STEP_DOWN = 2'd2
	} step_event_t;

	typedef struct packed {
		logic os_is_mac;
		logic [STEP_W-1:0]  step_mac;
		logic [STEP_W-1:0]  step_win;
		logic [TICKS_W-1:0] debounce_ticks;
		logic [TICKS_W-1:0] overlay_ticks;
	} cfg_t;

	typedef struct packed {
		logic clk_level;
		logic dt_level;
		logic switch_level;
	} sample_t;

	typedef struct packed {
		logic [VOLUME_W-1:0] volume_level;
		logic [1:0]          step_event;
		logic                mute_event;
		logic                muted_flag;
		logic                overlay_active;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/evmc_cfg_regs.sv =====
`default_nettype none

module evmc_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_wr_en,
	input  wire logic [evmc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [evmc_pkg::CFG_W-1:0]     cfg_wdata,
	output evmc_pkg::cfg_t                      cfg
);
	import evmc_pkg::*;

	cfg_t cfg_q;

	// decode the index and store the write; unknown indexes are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.os_is_mac      <= 1'b0;
			cfg_q.step_mac       <= STEP_W'(512);
			cfg_q.step_win       <= STEP_W'(512);
			cfg_q.debounce_ticks <= TICKS_W'(200);
			cfg_q.overlay_ticks  <= TICKS_W'(1000);
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				CFG_OS_IS_MAC:      cfg_q.os_is_mac      <= cfg_wdata[0];
				CFG_STEP_MAC:       cfg_q.step_mac       <= cfg_wdata[STEP_W-1:0];
				CFG_STEP_WIN:       cfg_q.step_win       <= cfg_wdata[STEP_W-1:0];
				CFG_DEBOUNCE_TICKS: cfg_q.debounce_ticks <= cfg_wdata[TICKS_W-1:0];
				CFG_OVERLAY_TICKS:  cfg_q.overlay_ticks  <= cfg_wdata[TICKS_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// ===== rtl/encoder_volume_mute_control_core.sv =====
`default_nettype none

// channel  | valid         | stall         | payload
// ---------+---------------+---------------+-----------------------------
// sample   | sample_valid  | sample_stall  | sample (clk, dt, switch)
// result   | result_valid  | result_stall  | result (volume, events, flags)
// config   | cfg_wr_en     | none          | cfg_index, cfg_wdata
//
// One request per cycle while result_stall is low: a tick is registered at the
// input, then one pass of adder, clamp and counter logic updates the state and
// loads the result register, which raises result_valid.
// Reset clears the state and loads the default configuration; no sweep.
// A stalled result holds the result register; the input register still takes
// one more request, then sample_stall rises until the result is taken.

module encoder_volume_mute_control_core #(
	parameter int unsigned TIME_BITS = 16
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           sample_valid,
	output      logic                           sample_stall,
	input  wire evmc_pkg::sample_t              sample,
	output      logic                           result_valid,
	input  wire logic                           result_stall,
	output evmc_pkg::result_t                   result,
	input  wire logic                           cfg_wr_en,
	input  wire logic [evmc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [evmc_pkg::CFG_W-1:0]     cfg_wdata
);
	import evmc_pkg::*;

	localparam int unsigned CMP_W = (TIME_BITS > TICKS_W) ? TIME_BITS : TICKS_W;
	localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

	cfg_t cfg;

	evmc_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	// pipeline control
	logic    valid_s1, valid_s2;
	sample_t sample_s1;
	result_t result_s2;
	logic    adv_s2, load_s1;

	assign adv_s2       = valid_s1 && (!valid_s2 || !result_stall);
	assign load_s1      = !valid_s1 || adv_s2;
	assign sample_stall = !load_s1;

	// tick state
	logic                 last_clk_q, muted_q, held_q;
	logic [VOLUME_W-1:0]  volume_q;
	logic [TIME_BITS-1:0] since_q, overlay_q;

	logic                 pressed, step_hit, press_ok, restart;
	logic [STEP_W-1:0]    step;
	logic [VOLUME_W:0]    vol_sum;
	logic [VOLUME_W-1:0]  vol_up, vol_dn, vol_next;
	logic [TIME_BITS-1:0] since_inc, since_next, overlay_next;
	logic [1:0]           step_ev;
	logic                 muted_next, held_next;

	// one tick: counter, encoder step, switch, then overlay timer
	always_comb begin
		pressed   = !sample_s1.switch_level;
		since_inc = (since_q != TIME_MAX) ? since_q + 1'b1 : since_q;

		step    = cfg.os_is_mac ? cfg.step_mac : cfg.step_win;
		vol_sum = {1'b0, volume_q} + {1'b0, step};
		vol_up  = (vol_sum > {1'b0, VOLUME_MAX}) ? VOLUME_MAX : vol_sum[VOLUME_W-1:0];
		vol_dn  = (step >= volume_q) ? '0 : volume_q - step;

		step_hit = (sample_s1.clk_level != last_clk_q) && !muted_q;
		vol_next = volume_q;
		step_ev  = STEP_NONE;
		if (step_hit) begin
			if (sample_s1.dt_level != sample_s1.clk_level) begin
				vol_next = vol_up;
				step_ev  = STEP_UP;
			end else begin
				vol_next = vol_dn;
				step_ev  = STEP_DOWN;
			end
		end

		press_ok = pressed && !held_q &&
			(CMP_W'(since_inc) > CMP_W'(cfg.debounce_ticks));
		held_next = held_q;
		if (press_ok)
			held_next = 1'b1;
		else if (!pressed && held_q)
			held_next = 1'b0;
		since_next = press_ok ? '0 : since_inc;
		muted_next = muted_q ^ press_ok;

		restart = step_hit || press_ok;
		if (restart)
			overlay_next = TIME_BITS'(cfg.overlay_ticks);
		else if (overlay_q != '0)
			overlay_next = overlay_q - 1'b1;
		else
			overlay_next = overlay_q;
	end

	// advance the input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (load_s1)
			valid_s1 <= sample_valid;
	end

	always_ff @(posedge clk) begin
		if (load_s1 && sample_valid)
			sample_s1 <= sample;
	end

	// commit the tick and hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2   <= 1'b0;
			last_clk_q <= 1'b1;
			volume_q   <= '0;
			muted_q    <= 1'b0;
			held_q     <= 1'b0;
			since_q    <= '0;
			overlay_q  <= '0;
		end else begin
			if (adv_s2) begin
				valid_s2   <= 1'b1;
				last_clk_q <= sample_s1.clk_level;
				volume_q   <= vol_next;
				muted_q    <= muted_next;
				held_q     <= held_next;
				since_q    <= since_next;
				overlay_q  <= overlay_next;
			end else if (!result_stall) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			result_s2.volume_level   <= vol_next;
			result_s2.step_event     <= step_ev;
			result_s2.mute_event     <= press_ok;
			result_s2.muted_flag     <= muted_next;
			result_s2.overlay_active <= (overlay_next != '0);
		end
	end

	assign result_valid = valid_s2;
	assign result       = result_s2;

	// checks
	a_stall_needs_s1: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> valid_s1 && valid_s2)
		else $error("input stalled with a free stage");

	a_volume_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> result_s2.volume_level <= VOLUME_MAX)
		else $error("volume above full scale");

	a_step_code: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> result_s2.step_event != 2'd3)
		else $error("invalid step event code");

	a_step_unmuted: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && result_s2.step_event != STEP_NONE && !result_s2.mute_event
		|-> !result_s2.muted_flag)
		else $error("step taken while muted");

	a_volume_tracks: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s2 |=> result_s2.volume_level == volume_q)
		else $error("result volume differs from state");

endmodule

`default_nettype wire
